// ----- hw/rtl/dcv_pkg.sv -----
// Shared types and constants for the daily code verifier.
package dcv_pkg;

   localparam logic        REQ_VERIFY = 1'b0;
   localparam logic        REQ_MARK   = 1'b1;

   localparam logic [16:0] PM_Q       = 17'd127773;
   localparam logic [14:0] PM_A       = 15'd16807;
   localparam logic [11:0] PM_R       = 12'd2836;
   localparam logic [30:0] PM_M       = 31'h7FFF_FFFF;
   localparam logic [13:0] HALF_BASE  = 14'd1000;
   localparam logic [13:0] HALF_SPAN  = 14'd9000;
   localparam logic [13:0] HALF_SCALE = 14'd10000;

   localparam logic [17:0] PM_RECIP   = 18'((64'd1 << 34) / 64'd127773);
   localparam logic [20:0] HALF_RECIP = 21'((64'd1 << 34) / 64'd9000);

   localparam int          HALF_LAT   = 8;

   typedef enum logic [2:0] {
      STS_OK       = 3'd0,
      STS_USED     = 3'd1,
      STS_INVALID  = 3'd2,
      STS_RECORDED = 3'd3,
      STS_FULL     = 3'd4
   } dcv_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_SCAN,
      S_DONE
   } dcv_state_type;

   typedef struct packed {
      logic       last;
      logic [7:0] coin;
   } dcv_tag_type;

endpackage

// ----- hw/rtl/dcv_ram.sv -----
// Generic single-port-write, registered-read RAM.
module dcv_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 512
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hw/rtl/dcv_half.sv -----
// Pipelined code half: one Park-Miller step from a seed, mod 9000 plus 1000.
module dcv_half (
   input  logic        clock,
   input  logic [31:0] seed,
   output logic [13:0] half
);
   import dcv_pkg::*;

   logic [35:0] p1_ff, p1_in;
   logic [31:0] s1_ff;
   logic [31:0] m2_ff, m2_in;
   logic [15:0] q2_ff, q2_in;
   logic [31:0] s2_ff;
   logic [16:0] r3_ff, r3_in;
   logic [15:0] q3_ff, q3_in;
   logic [17:0] r3_raw;
   logic [30:0] hi4_ff, hi4_in;
   logic [27:0] lo4_ff, lo4_in;
   logic [30:0] t5_ff, t5_in;
   logic [30:0] lo_ext;
   logic [41:0] p6_ff, p6_in;
   logic [30:0] t6_ff;
   logic [30:0] m7_ff, m7_in;
   logic [30:0] t7_ff;
   logic [17:0] q7;
   logic [14:0] r8_raw;
   logic [13:0] r8;
   logic [13:0] half_ff, half_in;

   always_comb begin
      p1_in  = 36'(seed[31:14]) * 36'(PM_RECIP);
      q2_in  = p1_ff[35:20];
      m2_in  = 32'(q2_in) * 32'(PM_Q);
      r3_raw = 18'(s2_ff - m2_ff);
      if (r3_raw >= 18'(PM_Q)) begin
         r3_in = 17'(r3_raw - 18'(PM_Q));
         q3_in = q2_ff + 16'd1;
      end else begin
         r3_in = r3_raw[16:0];
         q3_in = q2_ff;
      end
      hi4_in = 31'(32'(r3_ff) * 32'(PM_A));
      lo4_in = 28'(28'(q3_ff) * 28'(PM_R));
      lo_ext = 31'(lo4_ff);
      if (hi4_ff > lo_ext) begin
         t5_in = hi4_ff - lo_ext;
      end else begin
         t5_in = PM_M - (lo_ext - hi4_ff);
      end
      p6_in  = 42'(t5_ff[30:10]) * 42'(HALF_RECIP);
      q7     = p6_ff[41:24];
      m7_in  = 31'(31'(q7) * 31'(HALF_SPAN));
      r8_raw = 15'(t7_ff - m7_ff);
      if (r8_raw >= 15'(HALF_SPAN)) begin
         r8 = 14'(r8_raw - 15'(HALF_SPAN));
      end else begin
         r8 = r8_raw[13:0];
      end
      half_in = r8 + HALF_BASE;
   end

   always_ff @(posedge clock) begin
      p1_ff   <= p1_in;
      s1_ff   <= seed;
      m2_ff   <= m2_in;
      q2_ff   <= q2_in;
      s2_ff   <= s1_ff;
      r3_ff   <= r3_in;
      q3_ff   <= q3_in;
      hi4_ff  <= hi4_in;
      lo4_ff  <= lo4_in;
      t5_ff   <= t5_in;
      p6_ff   <= p6_in;
      t6_ff   <= t5_ff;
      m7_ff   <= m7_in;
      t7_ff   <= t6_ff;
      half_ff <= half_in;
   end

   assign half = half_ff;
endmodule

// ----- hw/rtl/daily_code_verifier.sv -----
// Daily code verifier top level: request FSM, pair search and used-code list.
//
// Request channel (req_*): one word per request; req_type selects verify or
// mark-used. Response channel (rsp_*): one word per request with status and
// coin value. csr_wr_en/csr_wr_data write the device serial (reset 1234).
// Mark-used: the code is appended (or STS_FULL is given) and the FSM goes to
// S_DONE; rsp_valid rises when the result loads into the output register.
// Verify: coin and slot pairs are tried in order until the first match, and a
// match then scans the used list for the code before the result is ready.
// With no match all (COIN_LIMIT-1)*SLOTS_PER_DAY pairs are tried before
// STS_INVALID is given. Two eight-stage half pipelines take one pair per cycle;
// the list is scanned one entry per cycle. One request is in flight at a time;
// req_stall is high from accept until the result moves into the output register,
// so the next word is taken while a result waits on a stalled rsp_stall; a
// finished result waits in S_DONE while the output register is held by rsp_stall.
// Reset empties the used list (fill count to zero), clears the stored date,
// restores the serial and drops any pending response. No clearing pass runs.
module daily_code_verifier #(
   parameter int COIN_LIMIT    = 15,
   parameter int SLOTS_PER_DAY = 25,
   parameter int USED_DEPTH    = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [26:0] req_code,
   input  logic [19:0] req_date_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_coin_count,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import dcv_pkg::*;

   localparam int COIN_W = $clog2(COIN_LIMIT);
   localparam int SLOT_W = (SLOTS_PER_DAY > 1) ? $clog2(SLOTS_PER_DAY) : 1;
   localparam int CNT_W  = $clog2(USED_DEPTH + 1);
   localparam int ADDR_W = (USED_DEPTH > 1) ? $clog2(USED_DEPTH) : 1;
   localparam logic [COIN_W-1:0] COIN_MAX = COIN_W'(COIN_LIMIT - 1);
   localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(SLOTS_PER_DAY - 1);

   dcv_state_type  state_ff, state_in;
   logic [15:0]    serial_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [19:0]    last_date_ff, last_date_in;
   logic [26:0]    code_ff, code_in;
   logic [19:0]    date_ff, date_in;
   logic [COIN_W-1:0] coin_ff, coin_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic           issuing_ff, issuing_in;
   logic [CNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic           pend_ff, pend_in;
   dcv_status_type res_status_ff, res_status_in;
   logic [3:0]     res_coin_ff, res_coin_in;
   logic [7:0]     hit_coin_ff, hit_coin_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [2:0]     rsp_status_ff;
   logic [3:0]     rsp_coin_ff;

   logic           issue, issue_last, load, hit, flush;
   logic           ram_we;
   logic [26:0]    ram_rd_data;
   logic [7:0]     slot8, coin8;
   logic [31:0]    seed_date, seed_coin;
   logic [13:0]    half_date, half_coin;

   logic           sv_ff   [HALF_LAT];
   logic           sv_in   [HALF_LAT];
   dcv_tag_type    stag_ff [HALF_LAT];
   dcv_tag_type    stag_in [HALF_LAT];
   logic           fv_ff, fv_in;
   dcv_tag_type    ftag_ff;
   logic [26:0]    full_ff, full_in;

   assign slot8     = 8'(slot_ff);
   assign coin8     = 8'(coin_ff);
   assign seed_date = {date_ff, 4'b0000, slot8};
   assign seed_coin = {serial_ff, slot8, coin8};

   dcv_half u_half_date (
      .clock (clock),
      .seed  (seed_date),
      .half  (half_date)
   );

   dcv_half u_half_coin (
      .clock (clock),
      .seed  (seed_coin),
      .half  (half_coin)
   );

   dcv_ram #(
      .WIDTH (27),
      .DEPTH (USED_DEPTH)
   ) u_used_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_code),
      .rd_addr (scan_idx_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign hit = fv_ff && (full_ff == code_ff) && (state_ff == S_SEARCH);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      last_date_in  = last_date_ff;
      code_in       = code_ff;
      date_in       = date_ff;
      coin_in       = coin_ff;
      slot_in       = slot_ff;
      issuing_in    = issuing_ff;
      scan_idx_in   = scan_idx_ff;
      pend_in       = 1'b0;
      res_status_in = res_status_ff;
      res_coin_in   = res_coin_ff;
      hit_coin_in   = hit_coin_ff;
      ram_we        = 1'b0;
      issue         = 1'b0;
      issue_last    = 1'b0;
      load          = 1'b0;
      req_stall     = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_type == REQ_MARK) begin
                  if (count_ff < CNT_W'(USED_DEPTH)) begin
                     ram_we        = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                     res_status_in = STS_RECORDED;
                  end else begin
                     res_status_in = STS_FULL;
                  end
                  res_coin_in = 4'd0;
                  state_in    = S_DONE;
               end else begin
                  code_in = req_code;
                  date_in = req_date_code;
                  if (req_date_code != last_date_ff) begin
                     count_in     = '0;
                     last_date_in = req_date_code;
                  end
                  coin_in    = COIN_W'(1);
                  slot_in    = '0;
                  issuing_in = 1'b1;
                  state_in   = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            if (issuing_ff) begin
               issue      = 1'b1;
               issue_last = (coin_ff == COIN_MAX) && (slot_ff == SLOT_MAX);
               if (issue_last) begin
                  issuing_in = 1'b0;
               end else if (slot_ff == SLOT_MAX) begin
                  slot_in = '0;
                  coin_in = coin_ff + COIN_W'(1);
               end else begin
                  slot_in = slot_ff + SLOT_W'(1);
               end
            end
            if (hit) begin
               hit_coin_in = ftag_ff.coin;
               scan_idx_in = '0;
               issuing_in  = 1'b0;
               state_in    = S_SCAN;
            end else if (fv_ff && ftag_ff.last) begin
               res_status_in = STS_INVALID;
               res_coin_in   = 4'd0;
               state_in      = S_DONE;
            end
         end
         S_SCAN: begin
            if (pend_ff && (ram_rd_data == code_ff)) begin
               res_status_in = STS_USED;
               res_coin_in   = 4'd0;
               state_in      = S_DONE;
            end else if (scan_idx_ff < count_ff) begin
               scan_idx_in = scan_idx_ff + CNT_W'(1);
               pend_in     = 1'b1;
            end else if (!pend_ff) begin
               res_status_in = STS_OK;
               res_coin_in   = hit_coin_ff[3:0];
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // advance the tag line alongside the half pipelines; drop it outside search
   always_comb begin
      flush      = (state_ff != S_SEARCH) || (state_in != S_SEARCH);
      sv_in[0]   = issue && !flush;
      stag_in[0] = '{last: issue_last, coin: coin8};
      for (int k = 1; k < HALF_LAT; k++) begin
         sv_in[k]   = sv_ff[k-1] && !flush;
         stag_in[k] = stag_ff[k-1];
      end
      fv_in   = sv_ff[HALF_LAT-1] && !flush;
      full_in = 27'(27'(half_date) * 27'(HALF_SCALE)) + 27'(half_coin);
   end

   always_comb begin
      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         serial_ff    <= 16'd1234;
         count_ff     <= '0;
         last_date_ff <= '0;
         issuing_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         fv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < HALF_LAT; k++) begin
            sv_ff[k] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            serial_ff <= csr_wr_data;
         end
         count_ff     <= count_in;
         last_date_ff <= last_date_in;
         issuing_ff   <= issuing_in;
         pend_ff      <= pend_in;
         fv_ff        <= fv_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < HALF_LAT; k++) begin
            sv_ff[k] <= sv_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      code_ff       <= code_in;
      date_ff       <= date_in;
      coin_ff       <= coin_in;
      slot_ff       <= slot_in;
      scan_idx_ff   <= scan_idx_in;
      res_status_ff <= res_status_in;
      res_coin_ff   <= res_coin_in;
      hit_coin_ff   <= hit_coin_in;
      ftag_ff       <= stag_ff[HALF_LAT-1];
      full_ff       <= full_in;
      for (int k = 0; k < HALF_LAT; k++) begin
         stag_ff[k] <= stag_in[k];
      end
      if (load) begin
         rsp_status_ff <= res_status_ff;
         rsp_coin_ff   <= res_coin_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_coin_count = rsp_coin_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(USED_DEPTH))
      else $error("used count beyond list depth");

   a_mark_append: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && req_type == REQ_MARK
       && count_ff < CNT_W'(USED_DEPTH))
      |=> count_ff == ($past(count_ff) + CNT_W'(1)))
      else $error("mark-used did not append");

   a_pipe_flushed: assert property (@(posedge clock) disable iff (reset)
      fv_ff |-> state_ff == S_SEARCH)
      else $error("stale pair result outside search");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised without a finished request");
endmodule

// ----- tb/daily_code_verifier_tb.sv -----
// Self-checking testbench for the daily code verifier: directed and random words.
`timescale 1ns / 1ps

module daily_code_verifier_tb;
   import dcv_pkg::*;

   localparam int          COINS          = 15;
   localparam int          SLOTS          = 25;
   localparam int          LIST_DEPTH     = 512;
   localparam int          HOLDOFF_CYCLES = 2000;
   localparam int          SETTLE_CYCLES  = 40;
   localparam logic [31:0] GEN_Q          = 32'd127773;
   localparam logic [31:0] GEN_A          = 32'd16807;
   localparam logic [31:0] GEN_R          = 32'd2836;
   localparam logic [31:0] GEN_M          = 32'h7FFF_FFFF;
   localparam logic [31:0] HALF_OFFSET    = 32'd1000;
   localparam logic [31:0] HALF_RANGE     = 32'd9000;
   localparam logic [31:0] HALF_WEIGHT    = 32'd10000;
   localparam logic [15:0] SERIAL_RESET   = 16'd1234;
   localparam logic [19:0] DATE_MAX       = 20'hFFFFF;
   localparam logic [26:0] CODE_MAX       = 27'd99999999;

   typedef struct {
      logic        kind;
      logic [26:0] code;
      logic [19:0] date;
   } request_word_type;

   typedef struct {
      dcv_status_type status;
      logic [3:0]     coin;
   } verdict_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic        req_type       = REQ_VERIFY;
   logic [26:0] req_code       = '0;
   logic [19:0] req_date_code  = '0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_coin_count;
   logic        csr_wr_en      = 1'b0;
   logic [15:0] csr_wr_data    = '0;

   request_word_type request_q[$];
   verdict_type      verdict_q[$];
   request_word_type shown_word;
   int            words_shown  = 0;
   int            words_taken  = 0;
   int            idle_pct     = 0;
   int            stall_pct    = 0;
   logic          holdoff_on   = 1'b0;
   logic          pressure_go  = 1'b0;
   int            mismatches   = 0;
   int            verify_count = 0;
   int            mark_count   = 0;
   int            status_seen[5] = '{default: 0};

   logic [26:0]   used_list[LIST_DEPTH];
   int            used_fill    = 0;
   logic [19:0]   seen_date    = '0;
   logic [15:0]   dev_serial   = SERIAL_RESET;

   logic [15:0]   gen_serial   = SERIAL_RESET;
   logic [19:0]   gen_date     = '0;
   logic [26:0]   recent_codes[$];

   daily_code_verifier u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_code       (req_code),
      .req_date_code  (req_date_code),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_coin_count (rsp_coin_count),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [31:0] code_half(input logic [31:0] seed);
      logic [31:0] q, r, hi, lo, t;
      q  = seed / GEN_Q;
      r  = seed % GEN_Q;
      hi = GEN_A * r;
      lo = GEN_R * q;
      if (hi > lo) t = hi - lo;
      else t = GEN_M - (lo - hi);
      return HALF_OFFSET + t % HALF_RANGE;
   endfunction

   function automatic logic [26:0] pair_code(input logic [19:0] date, input logic [15:0] serial,
                                             input int coin, input int slot);
      logic [31:0] stamp_seed, coin_seed;
      stamp_seed = {date, 12'd0} | {24'd0, slot[7:0]};
      coin_seed  = {serial, slot[7:0], coin[7:0]};
      return 27'(code_half(stamp_seed) * HALF_WEIGHT + code_half(coin_seed));
   endfunction

   function automatic verdict_type judge_request(input request_word_type w);
      verdict_type v;
      logic     hit;
      v.status = STS_INVALID;
      v.coin   = '0;
      hit      = 1'b0;
      if (w.kind == REQ_MARK) begin
         if (used_fill < LIST_DEPTH) begin
            used_list[used_fill] = w.code;
            used_fill++;
            v.status = STS_RECORDED;
         end else begin
            v.status = STS_FULL;
         end
      end else begin
         if (w.date != seen_date) begin
            used_fill = 0;
            seen_date = w.date;
         end
         for (int coin = 1; coin < COINS && !hit; coin++) begin
            for (int slot = 0; slot < SLOTS && !hit; slot++) begin
               if (pair_code(w.date, dev_serial, coin, slot) == w.code) begin
                  hit      = 1'b1;
                  v.status = STS_OK;
                  v.coin   = 4'(coin);
                  for (int i = 0; i < used_fill; i++) begin
                     if (used_list[i] == w.code) begin
                        v.status = STS_USED;
                        v.coin   = '0;
                     end
                  end
               end
            end
         end
      end
      return v;
   endfunction

   task automatic log_mismatch(input string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // predict on every accepted request word
   always @(posedge clock) begin
      if (reset) begin
         used_fill  = 0;
         seen_date  = '0;
         dev_serial = SERIAL_RESET;
      end else begin
         if (csr_wr_en) dev_serial = csr_wr_data;
         if (req_valid && !req_stall) begin
            verdict_q.push_back(judge_request(shown_word));
            if (shown_word.kind == REQ_MARK) mark_count++;
            else verify_count++;
            words_taken++;
         end
      end
   end

   // present the next word once the previous one is taken
   always @(negedge clock) begin
      if (!reset && words_shown == words_taken) begin
         if (request_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
            shown_word = request_q.pop_front();
            req_type      <= shown_word.kind;
            req_code      <= shown_word.code;
            req_date_code <= shown_word.date;
            req_valid     <= 1'b1;
            words_shown++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock)
      rsp_stall <= holdoff_on || ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin : response_check
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_status < 3'd5) status_seen[rsp_status]++;
         if (verdict_q.size() == 0) begin
            log_mismatch($sformatf("response with nothing pending: status %0d coin %0d",
                                   rsp_status, rsp_coin_count));
         end else begin
            want = verdict_q.pop_front();
            if (rsp_status !== want.status)
               log_mismatch($sformatf("status %0d, wanted %s", rsp_status, want.status.name()));
            if (rsp_coin_count !== want.coin)
               log_mismatch($sformatf("coin %0d, wanted %0d", rsp_coin_count, want.coin));
         end
      end
   end

   // hold the response side off once the last phase starts, then release it
   initial begin : receiver_holdoff
      wait (pressure_go);
      @(posedge clock);
      holdoff_on = 1'b1;
      repeat (HOLDOFF_CYCLES) @(posedge clock);
      holdoff_on = 1'b0;
   end

   initial begin : watchdog
      #80_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic wait_idle();
      while (request_q.size() > 0 || words_shown != words_taken || verdict_q.size() > 0)
         @(posedge clock);
   endtask

   task automatic start_phase(input logic [15:0] serial, input int sender_idle,
                              input int recv_stall);
      wait_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= serial;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
      gen_serial = serial;
      idle_pct   = sender_idle;
      stall_pct  = recv_stall;
   endtask

   task automatic add_word(input logic kind, input logic [26:0] code, input logic [19:0] date);
      request_word_type w;
      w.kind = kind;
      w.code = code;
      w.date = date;
      request_q.push_back(w);
   endtask

   function automatic logic [26:0] fresh_code();
      return pair_code(gen_date, gen_serial, $urandom_range(COINS - 1, 1),
                       $urandom_range(SLOTS - 1, 0));
   endfunction

   function automatic logic [26:0] noise_code();
      return 27'($urandom_range(CODE_MAX));
   endfunction

   task automatic add_mixed(input int n);
      logic [26:0] c;
      int          pick;
      repeat (n) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            case ($urandom_range(3))
               0: gen_date = '0;
               1: gen_date = DATE_MAX;
               default: gen_date = 20'($urandom);
            endcase
            recent_codes.delete();
            c = fresh_code();
            recent_codes.push_back(c);
            add_word(REQ_VERIFY, c, gen_date);
         end else if (pick < 45) begin
            c = fresh_code();
            recent_codes.push_back(c);
            add_word(REQ_VERIFY, c, gen_date);
         end else if (pick < 60) begin
            c = fresh_code();
            recent_codes.push_back(c);
            add_word(REQ_VERIFY, c, gen_date);
            add_word(REQ_MARK, c, 20'($urandom));
            add_word(REQ_VERIFY, c, gen_date);
         end else if (pick < 75) begin
            c = (recent_codes.size() > 0) ?
                recent_codes[$urandom_range(recent_codes.size() - 1)] : noise_code();
            add_word(REQ_MARK, c, 20'($urandom));
         end else if (pick < 85) begin
            c = (recent_codes.size() > 0) ?
                recent_codes[$urandom_range(recent_codes.size() - 1)] : fresh_code();
            add_word(REQ_VERIFY, c, gen_date);
         end else if (pick < 93) begin
            add_word(REQ_VERIFY, noise_code(), gen_date);
         end else begin
            add_word(REQ_MARK, noise_code(), 20'($urandom));
         end
         if (recent_codes.size() > 16) void'(recent_codes.pop_front());
      end
   endtask

   initial begin : stimulus
      logic [26:0] c;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      start_phase(SERIAL_RESET, 0, 0);
      add_word(REQ_VERIFY, '0, '0);
      add_word(REQ_VERIFY, CODE_MAX, DATE_MAX);
      add_word(REQ_VERIFY, pair_code(DATE_MAX, gen_serial, 1, 0), DATE_MAX);
      c = pair_code(DATE_MAX, gen_serial, COINS - 1, SLOTS - 1);
      add_word(REQ_VERIFY, c, DATE_MAX);
      add_word(REQ_MARK, c, '0);
      add_word(REQ_VERIFY, c, DATE_MAX);
      add_word(REQ_MARK, c, DATE_MAX);
      add_word(REQ_VERIFY, c, DATE_MAX);
      add_word(REQ_MARK, '0, DATE_MAX);
      add_word(REQ_MARK, CODE_MAX, '0);
      add_word(REQ_VERIFY, pair_code(DATE_MAX, gen_serial, 7, 12), DATE_MAX);
      add_word(REQ_VERIFY, pair_code(20'h12345, gen_serial, 3, 5), DATE_MAX);
      add_word(REQ_VERIFY, pair_code(DATE_MAX, 16'd4321, 3, 5), DATE_MAX);
      add_word(REQ_VERIFY, pair_code('0, gen_serial, COINS - 1, SLOTS - 1), '0);
      add_word(REQ_VERIFY, c, DATE_MAX);
      add_word(REQ_VERIFY, c, DATE_MAX);
      add_word(REQ_MARK, c, 20'h5A5A5);
      add_word(REQ_VERIFY, c, DATE_MAX);
      gen_date = DATE_MAX;

      start_phase(16'h0000, 50, 0);
      add_mixed(60);

      start_phase(16'hFFFF, 0, 50);
      add_mixed(60);

      // fill the used list past its depth, then look codes up against it
      start_phase(16'($urandom), 15, 15);
      gen_date = 20'($urandom);
      recent_codes.delete();
      add_word(REQ_VERIFY, fresh_code(), gen_date);
      for (int i = 0; i < LIST_DEPTH + 3; i++) begin
         if (i % 50 == 0) begin
            c = fresh_code();
            recent_codes.push_back(c);
         end else begin
            c = noise_code();
         end
         add_word(REQ_MARK, c, 20'($urandom));
      end
      foreach (recent_codes[i]) add_word(REQ_VERIFY, recent_codes[i], gen_date);
      repeat (4) add_word(REQ_VERIFY, fresh_code(), gen_date);
      recent_codes.delete();

      start_phase(SERIAL_RESET, 0, 0);
      pressure_go = 1'b1;
      add_mixed(60);

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (verdict_q.size() > 0)
         log_mismatch($sformatf("%0d responses never arrived", verdict_q.size()));
      $display("covered %0d verify and %0d mark-used words over five phases, list overflow too,",
               verify_count, mark_count);
      $display("responses: ok %0d used %0d invalid %0d recorded %0d list-full %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- daily_code_verifier.f -----
hw/rtl/dcv_pkg.sv
hw/rtl/dcv_ram.sv
hw/rtl/dcv_half.sv
hw/rtl/daily_code_verifier.sv
tb/daily_code_verifier_tb.sv
